// File: src/cbc_pkg.sv
// Shared types and constants for the cartridge bank controller.
package cbc_pkg;

    localparam int ROM_BANKS_DEF = 128;
    localparam int RAM_BANKS_DEF = 4;
    localparam int ROM_OFS_W     = 14;   // byte offset inside one ROM bank
    localparam int RAM_OFS_W     = 13;   // byte offset inside one RAM bank
    localparam int LOAD_OFS_W    = 21;
    localparam int BANK_NUM_W    = 7;
    localparam int OUTQ_DEPTH    = 3;

    localparam logic [3:0] RAM_EN_KEY    = 4'hA;
    localparam logic [7:0] UNMAPPED_BYTE = 8'hFF;

    // Bus regions by address[15:13]
    localparam logic [2:0] RGN_RAM_EN   = 3'd0;
    localparam logic [2:0] RGN_ROM_BANK = 3'd1;
    localparam logic [2:0] RGN_UPPER    = 3'd2;
    localparam logic [2:0] RGN_MODE     = 3'd3;
    localparam logic [2:0] RGN_RAM      = 3'd5;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_LOAD  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        SRC_FF  = 2'd0,
        SRC_ROM = 2'd1,
        SRC_RAM = 2'd2
    } t_src;

    typedef struct packed {
        logic rom_we;
        logic rom_re;
        logic ram_we;
        logic ram_re;
    } t_mem_req;

    typedef struct packed {
        logic vld;
        t_src src;
    } t_rd_tag;

endpackage

// File: src/cbc_bank_ctl.sv
// Bank control registers and bus decode into memory requests.
module cbc_bank_ctl #(
    parameter int ROM_BANKS = cbc_pkg::ROM_BANKS_DEF,
    parameter int RAM_BANKS = cbc_pkg::RAM_BANKS_DEF,
    localparam int ROM_BW = $clog2(ROM_BANKS),
    localparam int RAM_BW = (RAM_BANKS > 1) ? $clog2(RAM_BANKS) : 1,
    localparam int ROM_AW = ROM_BW + cbc_pkg::ROM_OFS_W,
    localparam int RAM_AW = RAM_BW + cbc_pkg::RAM_OFS_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic [1:0]           i_op,
    input  logic [15:0]          i_address,
    input  logic [7:0]           i_data,
    input  logic [20:0]          i_rom_offset,
    output cbc_pkg::t_mem_req    o_req,
    output logic [ROM_AW-1:0]    o_rom_addr,
    output logic [RAM_AW-1:0]    o_ram_addr,
    output cbc_pkg::t_rd_tag     o_tag
);

    localparam int ROM_DEPTH = ROM_BANKS * (2 ** cbc_pkg::ROM_OFS_W);

    cbc_pkg::t_op op;
    logic [2:0]   rgn;
    logic         is_rd, is_wr, is_ld, load_in_range;
    logic [4:0]   low_bank;
    logic [cbc_pkg::BANK_NUM_W-1:0] new_bank;
    logic [ROM_BW-1:0] rom_wrap;
    logic [RAM_BW-1:0] ram_wrap;

    logic [1:0]        r_upper, n_upper;
    logic              r_ram_en, n_ram_en;
    logic              r_ram_mode, n_ram_mode;
    logic [ROM_BW-1:0] r_rom_sel, n_rom_sel;
    logic [RAM_BW-1:0] r_ram_sel, n_ram_sel;

    assign op    = cbc_pkg::t_op'(i_op);
    assign rgn   = i_address[15:13];
    assign is_rd = i_fire && (op == cbc_pkg::OP_READ);
    assign is_wr = i_fire && (op == cbc_pkg::OP_WRITE);
    assign is_ld = i_fire && (op == cbc_pkg::OP_LOAD);
    assign load_in_range = {1'b0, i_rom_offset} < 22'(ROM_DEPTH);

    assign low_bank = (i_data[4:0] == 5'd0) ? 5'd1 : i_data[4:0];
    assign new_bank = {r_upper, low_bank};

    // Wrap bank numbers once at latch time so reads use them directly
    always_comb begin
        rom_wrap = '0;
        for (int i = 0; i < 2 ** cbc_pkg::BANK_NUM_W; i++) begin
            if (new_bank == cbc_pkg::BANK_NUM_W'(i)) rom_wrap = ROM_BW'(i % ROM_BANKS);
        end
        ram_wrap = '0;
        for (int j = 0; j < 4; j++) begin
            if (i_data[1:0] == 2'(j)) ram_wrap = RAM_BW'(j % RAM_BANKS);
        end
    end

    always_comb begin
        n_upper    = r_upper;
        n_ram_en   = r_ram_en;
        n_ram_mode = r_ram_mode;
        n_rom_sel  = r_rom_sel;
        n_ram_sel  = r_ram_sel;
        if (is_wr) begin
            unique case (rgn)
                cbc_pkg::RGN_RAM_EN:   n_ram_en = (i_data[3:0] == cbc_pkg::RAM_EN_KEY);
                cbc_pkg::RGN_ROM_BANK: n_rom_sel = rom_wrap;
                cbc_pkg::RGN_UPPER: begin
                    if (r_ram_mode) n_ram_sel = ram_wrap;
                    else            n_upper   = i_data[1:0];
                end
                cbc_pkg::RGN_MODE: begin
                    n_ram_mode = i_data[0];
                    if (!i_data[0]) n_ram_sel = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper    <= '0;
            r_ram_en   <= 1'b0;
            r_ram_mode <= 1'b0;
            r_rom_sel  <= ROM_BW'(1);   // bank zero reads as bank one
            r_ram_sel  <= '0;
        end else begin
            r_upper    <= n_upper;
            r_ram_en   <= n_ram_en;
            r_ram_mode <= n_ram_mode;
            r_rom_sel  <= n_rom_sel;
            r_ram_sel  <= n_ram_sel;
        end
    end

    assign o_req.rom_we = is_ld && load_in_range;
    assign o_req.rom_re = is_rd && !i_address[15];
    assign o_req.ram_we = is_wr && (rgn == cbc_pkg::RGN_RAM);
    assign o_req.ram_re = is_rd && (rgn == cbc_pkg::RGN_RAM) && r_ram_en;

    assign o_rom_addr = (op == cbc_pkg::OP_LOAD) ? i_rom_offset[ROM_AW-1:0]
                      : {(i_address[14] ? r_rom_sel : ROM_BW'(0)),
                         i_address[cbc_pkg::ROM_OFS_W-1:0]};
    assign o_ram_addr = {r_ram_sel, i_address[cbc_pkg::RAM_OFS_W-1:0]};

    assign o_tag.vld = is_rd;
    assign o_tag.src = o_req.rom_re ? cbc_pkg::SRC_ROM
                     : o_req.ram_re ? cbc_pkg::SRC_RAM : cbc_pkg::SRC_FF;

endmodule

// File: src/cbc_mem.sv
// Cartridge ROM and RAM stores with registered read data.
module cbc_mem #(
    parameter int ROM_BANKS = cbc_pkg::ROM_BANKS_DEF,
    parameter int RAM_BANKS = cbc_pkg::RAM_BANKS_DEF,
    localparam int ROM_BW = $clog2(ROM_BANKS),
    localparam int RAM_BW = (RAM_BANKS > 1) ? $clog2(RAM_BANKS) : 1,
    localparam int ROM_AW = ROM_BW + cbc_pkg::ROM_OFS_W,
    localparam int RAM_AW = RAM_BW + cbc_pkg::RAM_OFS_W
) (
    input  logic              i_clk,
    input  cbc_pkg::t_mem_req i_req,
    input  logic [ROM_AW-1:0] i_rom_addr,
    input  logic [RAM_AW-1:0] i_ram_addr,
    input  logic [7:0]        i_wdata,
    output logic [7:0]        o_rom_q,
    output logic [7:0]        o_ram_q
);

    localparam int ROM_DEPTH = ROM_BANKS * (2 ** cbc_pkg::ROM_OFS_W);
    localparam int RAM_DEPTH = RAM_BANKS * (2 ** cbc_pkg::RAM_OFS_W);

    logic [7:0] r_rom [ROM_DEPTH];
    logic [7:0] r_ram [RAM_DEPTH];
    logic [7:0] r_rom_q, r_ram_q;

    always_ff @(posedge i_clk) begin
        if (i_req.rom_we) r_rom[i_rom_addr] <= i_wdata;
        if (i_req.rom_re) r_rom_q <= r_rom[i_rom_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ram_we) r_ram[i_ram_addr] <= i_wdata;
        if (i_req.ram_re) r_ram_q <= r_ram[i_ram_addr];
    end

    assign o_rom_q = r_rom_q;
    assign o_ram_q = r_ram_q;

endmodule

// File: src/cbc_outq.sv
// Three-entry result queue between the memory read stage and the output port.
module cbc_outq (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_push_data,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_data,
    output logic [1:0] o_count
);

    localparam int QD = cbc_pkg::OUTQ_DEPTH;

    logic [7:0] r_ent [QD];
    logic [1:0] r_wp, n_wp, r_rp, n_rp, r_cnt, n_cnt;
    logic       pop;

    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid && i_ready;
    assign o_data  = r_ent[r_rp];
    assign o_count = r_cnt;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) n_wp = (r_wp == 2'(QD - 1)) ? 2'd0 : r_wp + 2'd1;
        if (pop)    n_rp = (r_rp == 2'(QD - 1)) ? 2'd0 : r_rp + 2'd1;
        if (i_push && !pop)      n_cnt = r_cnt + 2'd1;
        else if (pop && !i_push) n_cnt = r_cnt - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_ent[r_wp] <= i_push_data;
    end

endmodule

// File: src/cartridge_bank_controller.sv
// Cartridge bank controller: bus decode, ROM/RAM stores and result queue.
// Read path: the store is read at the edge that accepts a read beat, the byte enters
// the result queue at the next edge and is offered from then on.
// Throughput: one beat per cycle; writes and loads take one store access.
// Input stalls only when the three-entry result queue backs up.
// Reset (i_rst_n low, synchronous) clears bank registers and queue; stores keep contents.
module cartridge_bank_controller #(
    parameter int ROM_BANKS = cbc_pkg::ROM_BANKS_DEF,
    parameter int RAM_BANKS = cbc_pkg::RAM_BANKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_data,
    input  logic [20:0] i_rom_offset,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_read_data
);

    localparam int ROM_BW = $clog2(ROM_BANKS);
    localparam int RAM_BW = (RAM_BANKS > 1) ? $clog2(RAM_BANKS) : 1;
    localparam int ROM_AW = ROM_BW + cbc_pkg::ROM_OFS_W;
    localparam int RAM_AW = RAM_BW + cbc_pkg::RAM_OFS_W;

    cbc_pkg::t_mem_req req;
    cbc_pkg::t_rd_tag  tag;
    logic [ROM_AW-1:0] rom_addr;
    logic [RAM_AW-1:0] ram_addr;
    logic [7:0]        rom_q, ram_q, rd_byte;
    logic [1:0]        q_cnt;
    logic              fire;

    logic          r_s1_vld;
    cbc_pkg::t_src r_s1_src;

    assign fire = i_in_valid && o_in_ready;

    // Hold input while pending reads could overflow the queue
    assign o_in_ready = r_s1_vld ? (q_cnt < 2'd2) : (q_cnt < 2'd3);

    cbc_bank_ctl #(.ROM_BANKS(ROM_BANKS), .RAM_BANKS(RAM_BANKS)) u_ctl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_op         (i_op),
        .i_address    (i_address),
        .i_data       (i_data),
        .i_rom_offset (i_rom_offset),
        .o_req        (req),
        .o_rom_addr   (rom_addr),
        .o_ram_addr   (ram_addr),
        .o_tag        (tag)
    );

    cbc_mem #(.ROM_BANKS(ROM_BANKS), .RAM_BANKS(RAM_BANKS)) u_mem (
        .i_clk      (i_clk),
        .i_req      (req),
        .i_rom_addr (rom_addr),
        .i_ram_addr (ram_addr),
        .i_wdata    (i_data),
        .o_rom_q    (rom_q),
        .o_ram_q    (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= tag.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_src <= tag.src;
    end

    always_comb begin
        unique case (r_s1_src)
            cbc_pkg::SRC_ROM: rd_byte = rom_q;
            cbc_pkg::SRC_RAM: rd_byte = ram_q;
            default:          rd_byte = cbc_pkg::UNMAPPED_BYTE;
        endcase
    end

    cbc_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_s1_vld),
        .i_push_data (rd_byte),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_data      (o_read_data),
        .o_count     (q_cnt)
    );

endmodule

// File: src/cbc_checker.sv
// Port-level checks for the cartridge bank controller, bound to the top level.
module cbc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [1:0]  i_op,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  o_read_data
);

    // Stalled result beat holds valid and data
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_read_data))
        else $error("result beat changed while stalled");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered right after reset");

    // Every accepted read reaches the output through the store read register and the queue
    a_read_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_op == cbc_pkg::OP_READ) |-> ##2 o_out_valid)
        else $error("read result missing two cycles after accept");

    // Input only stalls behind queued results
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result pending");

endmodule

bind cartridge_bank_controller cbc_checker u_cbc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_op        (i_op),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_read_data (o_read_data)
);
